/* sv/tkc_pkg.sv */
// Package for the typed key comparator: type codes, result codes, front-to-back beat struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tkc_pkg;

   localparam int unsigned MaxKeyWordsDefault = 1024;
   localparam int unsigned BlobHeadWordsDefault = 2;
   localparam int unsigned KindWidth = 5;
   localparam int unsigned FullWidth = 11;
   localparam int unsigned OrderWidth = 3;
   localparam logic [7:0] MinusChar = 8'h2d;

   typedef enum logic [4:0] {
      KIND_TINYINT = 5'd1, KIND_TINYUNS = 5'd2, KIND_SMALLINT = 5'd3,
      KIND_SMALLUNS = 5'd4, KIND_MEDINT = 5'd5, KIND_MEDUNS = 5'd6,
      KIND_INT = 5'd7, KIND_UNS = 5'd8, KIND_BIGINT = 5'd9, KIND_BIGUNS = 5'd10,
      KIND_FLOAT = 5'd11, KIND_DOUBLE = 5'd12, KIND_OLDDEC = 5'd13,
      KIND_CHAR = 5'd14, KIND_VARCHAR = 5'd15, KIND_BINARY = 5'd16,
      KIND_VARBIN = 5'd17, KIND_DATETIME = 5'd18, KIND_DATE = 5'd19,
      KIND_BLOB = 5'd20, KIND_TEXT = 5'd21, KIND_TIME = 5'd25,
      KIND_YEAR = 5'd26, KIND_TSTAMP = 5'd27, KIND_OLDDECUNS = 5'd28
   } kind_type;

   typedef enum logic [1:0] {
      CLS_WORD = 2'd0, CLS_WIDE = 2'd1, CLS_BYTES = 2'd2, CLS_NONE = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      MODE_BYTES = 2'd0, MODE_STRING = 2'd1, MODE_DECIMAL = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      VERDICT_NONE = 2'd0, VERDICT_LESS = 2'd1, VERDICT_GREATER = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      ORDER_LESS = 3'd0, ORDER_EQUAL = 3'd1, ORDER_GREATER = 3'd2,
      ORDER_UNKNOWN = 3'd3, ORDER_UNSUPPORTED = 3'd4
   } order_type;

   // classified beat handed from front to back
   typedef struct packed {
      logic [4:0] kind;
      class_type cls;
      mode_type mode;
      logic [3:0] skip_bytes;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [10:0] full_words;
      logic last;
   } beat_type;

endpackage
`default_nettype wire

/* sv/typed_key_comparator.sv */
// Typed key comparator top level: front classifier, two-beat queue, back compare engine.
// Depends on tkc_pkg, tkc_front, tkc_back.
//
// Usage: each request beat carries one word of each key plus the type code, the full key
// length in words and a last flag. Beats of one key pair stream in back to back; only the
// beat with tlast set yields a response beat holding the order code (less, equal, greater,
// unknown, unsupported).
// Throughput: one request beat per cycle, set by the single-beat compare in the back end,
// as long as the receiver does not stall. With nothing queued ahead, a last beat passes
// through the queue and then the output register before it reaches the response channel.
// Reset clears the queue, the per-key state and the response valid flag.
// When the receiver stalls, the response register holds; the back end stops taking beats and
// the two-entry queue fills, after which req_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module typed_key_comparator #(
   parameter int unsigned MAX_KEY_WORDS = tkc_pkg::MaxKeyWordsDefault,
   parameter int unsigned BLOB_HEAD_WORDS = tkc_pkg::BlobHeadWordsDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [79:0] req_tdata, // word_a[31:0], word_b[63:32], full_words[74:64], zeros
   input wire logic [4:0] req_tuser,  // kind
   input wire logic req_tlast,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [7:0] rsp_tdata       // order[2:0], zeros
);

   logic q_valid, q_ready;
   tkc_pkg::beat_type q_beat;
   logic unused_pad;

   assign unused_pad = ^req_tdata[79:75];

   tkc_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_kind(req_tuser), .req_word_a(req_tdata[31:0]), .req_word_b(req_tdata[63:32]),
      .req_full_words(req_tdata[74:64]), .req_last(req_tlast),
      .q_valid(q_valid), .q_ready(q_ready), .q_beat(q_beat)
   );

   tkc_back #(.MAX_KEY_WORDS(MAX_KEY_WORDS), .BLOB_HEAD_WORDS(BLOB_HEAD_WORDS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_beat(q_beat),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

endmodule
`default_nettype wire

/* sv/tkc_front.sv */
// Front end: accepts request beats, classifies the type code, pushes into a 2-entry queue.
// Depends on tkc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tkc_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [4:0] req_kind,
   input wire logic [31:0] req_word_a,
   input wire logic [31:0] req_word_b,
   input wire logic [10:0] req_full_words,
   input wire logic req_last,
   output logic q_valid,
   input wire logic q_ready,
   output tkc_pkg::beat_type q_beat
);

   tkc_pkg::beat_type slot_ff [2];
   tkc_pkg::beat_type slot_in;
   logic [1:0] count_ff, count_in;
   logic rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic push, pop;

   always_comb begin
      slot_in.kind = req_kind;
      slot_in.word_a = req_word_a;
      slot_in.word_b = req_word_b;
      slot_in.full_words = req_full_words;
      slot_in.last = req_last;
      slot_in.mode = tkc_pkg::MODE_BYTES;
      slot_in.skip_bytes = 4'd0;
      case (req_kind) inside
         tkc_pkg::KIND_TINYINT, tkc_pkg::KIND_TINYUNS, tkc_pkg::KIND_SMALLINT,
         tkc_pkg::KIND_SMALLUNS, tkc_pkg::KIND_MEDINT, tkc_pkg::KIND_MEDUNS,
         tkc_pkg::KIND_INT, tkc_pkg::KIND_UNS, tkc_pkg::KIND_FLOAT,
         tkc_pkg::KIND_DATE, tkc_pkg::KIND_TIME, tkc_pkg::KIND_YEAR,
         tkc_pkg::KIND_TSTAMP: slot_in.cls = tkc_pkg::CLS_WORD;
         tkc_pkg::KIND_BIGINT, tkc_pkg::KIND_BIGUNS, tkc_pkg::KIND_DOUBLE,
         tkc_pkg::KIND_DATETIME: slot_in.cls = tkc_pkg::CLS_WIDE;
         tkc_pkg::KIND_OLDDEC, tkc_pkg::KIND_OLDDECUNS: begin
            slot_in.cls = tkc_pkg::CLS_BYTES;
            slot_in.mode = tkc_pkg::MODE_DECIMAL;
         end
         tkc_pkg::KIND_VARCHAR: begin
            slot_in.cls = tkc_pkg::CLS_BYTES;
            slot_in.mode = tkc_pkg::MODE_STRING;
            slot_in.skip_bytes = 4'd2;
         end
         tkc_pkg::KIND_BINARY: slot_in.cls = tkc_pkg::CLS_BYTES;
         tkc_pkg::KIND_VARBIN: begin
            slot_in.cls = tkc_pkg::CLS_BYTES;
            slot_in.skip_bytes = 4'd2;
         end
         tkc_pkg::KIND_BLOB: begin
            slot_in.cls = tkc_pkg::CLS_BYTES;
            slot_in.skip_bytes = 4'd0; // blob head handled by word index in back
         end
         default: slot_in.cls = tkc_pkg::CLS_NONE;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push = req_tvalid && req_tready;
   assign q_valid = (count_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_beat = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) count_ff == 2'd2 |-> !push;
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

   property p_count_track;
      @(posedge clock) disable iff (reset)
         (push && !pop && count_ff != 2'd2) |=> count_ff == $past(count_ff) + 2'd1;
   endproperty
   a_count_track: assert property (p_count_track) else $error("queue count slip");

   property p_empty_no_pop;
      @(posedge clock) disable iff (reset) count_ff == 2'd0 |-> !q_valid;
   endproperty
   a_empty_no_pop: assert property (p_empty_no_pop) else $error("pop from empty");

endmodule
`default_nettype wire

/* sv/tkc_back.sv */
// Back end: carries out each classified beat, keeps the per-key verdict, emits the order.
// Depends on tkc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tkc_back #(
   parameter int unsigned MAX_KEY_WORDS = tkc_pkg::MaxKeyWordsDefault,
   parameter int unsigned BLOB_HEAD_WORDS = tkc_pkg::BlobHeadWordsDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic q_valid,
   output logic q_ready,
   input wire tkc_pkg::beat_type q_beat,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [7:0] rsp_tdata
);

   localparam int unsigned CntWidth = $clog2(MAX_KEY_WORDS + 1);
   localparam int unsigned CmpWidth = (CntWidth > 11) ? CntWidth : 11;

   logic [CntWidth-1:0] seen_ff, seen_in;
   tkc_pkg::verdict_type verdict_ff, verdict_in;
   logic [31:0] low_a_ff, low_a_in, low_b_ff, low_b_in;
   logic neg_ff, neg_in, ended_ff, ended_in;
   logic out_valid_ff, out_valid_in;
   logic [2:0] out_order_ff, out_order_in;

   logic take, below_max, first_word, second_word;
   logic [7:0] ca, cb;
   tkc_pkg::verdict_type wv, dv, bv;
   logic [63:0] va, vb, wa, wb;
   logic nan_a, nan_b;
   logic [CmpWidth-1:0] size_w, full_w;
   logic [CmpWidth+2:0] base_byte, byte_pos, skip_w;
   logic [2:0] ord;
   logic complete, decided;

   function automatic tkc_pkg::verdict_type rel64(input logic [63:0] a, input logic [63:0] b);
      if (a < b) return tkc_pkg::VERDICT_LESS;
      else if (a > b) return tkc_pkg::VERDICT_GREATER;
      return tkc_pkg::VERDICT_NONE;
   endfunction

   function automatic logic [31:0] fkey(input logic [31:0] w);
      if (w[30:0] == 31'd0) return 32'h8000_0000;
      if (w[31]) return ~w;
      return w | 32'h8000_0000;
   endfunction

   function automatic logic [63:0] dkey(input logic [63:0] w);
      if (w[62:0] == 63'd0) return 64'h8000_0000_0000_0000;
      if (w[63]) return ~w;
      return w | 64'h8000_0000_0000_0000;
   endfunction

   assign q_ready = !out_valid_ff || rsp_tready;
   assign take = q_valid && q_ready;
   assign below_max = (CmpWidth'(seen_ff) < CmpWidth'(MAX_KEY_WORDS));
   assign first_word = (seen_ff == '0);
   assign second_word = (seen_ff == CntWidth'(1));

   // single-word compare
   always_comb begin
      wa = {32'd0, q_beat.word_a};
      wb = {32'd0, q_beat.word_b};
      case (q_beat.kind) inside
         tkc_pkg::KIND_TINYINT: begin
            wa = {56'd0, q_beat.word_a[7:0] ^ 8'h80};
            wb = {56'd0, q_beat.word_b[7:0] ^ 8'h80};
         end
         tkc_pkg::KIND_TINYUNS, tkc_pkg::KIND_YEAR: begin
            wa = {56'd0, q_beat.word_a[7:0]};
            wb = {56'd0, q_beat.word_b[7:0]};
         end
         tkc_pkg::KIND_SMALLINT: begin
            wa = {48'd0, q_beat.word_a[15:0] ^ 16'h8000};
            wb = {48'd0, q_beat.word_b[15:0] ^ 16'h8000};
         end
         tkc_pkg::KIND_SMALLUNS: begin
            wa = {48'd0, q_beat.word_a[15:0]};
            wb = {48'd0, q_beat.word_b[15:0]};
         end
         tkc_pkg::KIND_MEDINT, tkc_pkg::KIND_TIME: begin
            wa = {40'd0, q_beat.word_a[23:0] ^ 24'h80_0000};
            wb = {40'd0, q_beat.word_b[23:0] ^ 24'h80_0000};
         end
         tkc_pkg::KIND_MEDUNS, tkc_pkg::KIND_DATE: begin
            wa = {40'd0, q_beat.word_a[23:0]};
            wb = {40'd0, q_beat.word_b[23:0]};
         end
         tkc_pkg::KIND_INT: begin
            wa = {32'd0, q_beat.word_a ^ 32'h8000_0000};
            wb = {32'd0, q_beat.word_b ^ 32'h8000_0000};
         end
         tkc_pkg::KIND_FLOAT: begin
            wa = {32'd0, fkey(q_beat.word_a)};
            wb = {32'd0, fkey(q_beat.word_b)};
         end
         default: ;
      endcase
      nan_a = (q_beat.word_a[30:23] == 8'hff) && (q_beat.word_a[22:0] != 23'd0);
      nan_b = (q_beat.word_b[30:23] == 8'hff) && (q_beat.word_b[22:0] != 23'd0);
      wv = rel64(wa, wb);
      if (q_beat.kind == tkc_pkg::KIND_FLOAT && (nan_a || nan_b)) begin
         wv = tkc_pkg::VERDICT_NONE;
      end
   end

   // two-word compare
   always_comb begin
      va = {q_beat.word_a, low_a_ff};
      vb = {q_beat.word_b, low_b_ff};
      dv = rel64({q_beat.word_a ^ 32'h8000_0000, low_a_ff},
                 {q_beat.word_b ^ 32'h8000_0000, low_b_ff});
      if (q_beat.kind == tkc_pkg::KIND_BIGUNS) begin
         dv = rel64(va, vb);
      end else if (q_beat.kind == tkc_pkg::KIND_DOUBLE) begin
         if (((va[62:52] == 11'h7ff) && (va[51:0] != 52'd0)) ||
             ((vb[62:52] == 11'h7ff) && (vb[51:0] != 52'd0))) begin
            dv = tkc_pkg::VERDICT_NONE;
         end else begin
            dv = rel64(dkey(va), dkey(vb));
         end
      end
   end

   // bytewise walk over the four byte lanes of the beat
   always_comb begin
      bv = verdict_ff;
      neg_in = neg_ff;
      ended_in = ended_ff;
      base_byte = (CmpWidth+3)'({seen_ff, 2'b00});
      skip_w = (q_beat.kind == tkc_pkg::KIND_BLOB) ? (CmpWidth+3)'(BLOB_HEAD_WORDS * 4)
                                                 : (CmpWidth+3)'(q_beat.skip_bytes);
      ca = 8'd0;
      cb = 8'd0;
      byte_pos = '0;
      for (int i = 0; i < 4; i++) begin
         ca = q_beat.word_a[8*i +: 8];
         cb = q_beat.word_b[8*i +: 8];
         byte_pos = base_byte + (CmpWidth+3)'(i);
         if (byte_pos >= skip_w && bv == tkc_pkg::VERDICT_NONE &&
             !(q_beat.mode == tkc_pkg::MODE_STRING && ended_in)) begin
            if (q_beat.mode == tkc_pkg::MODE_DECIMAL) begin
               if (ca == cb) begin
                  if (ca == tkc_pkg::MinusChar) neg_in = 1'b1;
               end else if (ca == tkc_pkg::MinusChar) begin
                  bv = tkc_pkg::VERDICT_LESS;
               end else if (cb == tkc_pkg::MinusChar) begin
                  bv = tkc_pkg::VERDICT_GREATER;
               end else begin
                  bv = ((ca < cb) ^ neg_in) ? tkc_pkg::VERDICT_LESS
                                           : tkc_pkg::VERDICT_GREATER;
               end
            end else if (ca != cb) begin
               bv = (ca < cb) ? tkc_pkg::VERDICT_LESS : tkc_pkg::VERDICT_GREATER;
            end else if (q_beat.mode == tkc_pkg::MODE_STRING && ca == 8'd0) begin
               ended_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      verdict_in = verdict_ff;
      low_a_in = low_a_ff;
      low_b_in = low_b_ff;
      seen_in = seen_ff;
      if (below_max) begin
         seen_in = seen_ff + CntWidth'(1);
         case (q_beat.cls)
            tkc_pkg::CLS_WORD: if (first_word) verdict_in = wv;
            tkc_pkg::CLS_WIDE: begin
               if (first_word) begin
                  low_a_in = q_beat.word_a;
                  low_b_in = q_beat.word_b;
               end else if (second_word) begin
                  verdict_in = dv;
               end
            end
            tkc_pkg::CLS_BYTES: verdict_in = bv;
            default: ;
         endcase
      end

      size_w = CmpWidth'(seen_in);
      full_w = CmpWidth'(q_beat.full_words);
      complete = (size_w == full_w);
      decided = (verdict_in != tkc_pkg::VERDICT_NONE);
      case (verdict_in)
         tkc_pkg::VERDICT_LESS: ord = tkc_pkg::ORDER_LESS;
         tkc_pkg::VERDICT_GREATER: ord = tkc_pkg::ORDER_GREATER;
         default: ord = tkc_pkg::ORDER_EQUAL;
      endcase
      case (q_beat.cls)
         tkc_pkg::CLS_WORD: ;
         tkc_pkg::CLS_WIDE: if (size_w < CmpWidth'(2)) ord = tkc_pkg::ORDER_UNKNOWN;
         tkc_pkg::CLS_BYTES: begin
            if (q_beat.mode == tkc_pkg::MODE_DECIMAL) begin
               if (!complete) ord = tkc_pkg::ORDER_UNKNOWN;
            end else if (q_beat.kind == tkc_pkg::KIND_BLOB) begin
               if (size_w < CmpWidth'(BLOB_HEAD_WORDS + 1) || (!decided && !complete))
                  ord = tkc_pkg::ORDER_UNKNOWN;
            end else if (!decided && !complete) begin
               ord = tkc_pkg::ORDER_UNKNOWN;
            end
         end
         default: ord = tkc_pkg::ORDER_UNSUPPORTED;
      endcase
      if (ord != tkc_pkg::ORDER_UNSUPPORTED && (full_w == '0 || size_w > full_w)) begin
         ord = tkc_pkg::ORDER_UNKNOWN;
      end

      out_valid_in = out_valid_ff && !rsp_tready;
      out_order_in = out_order_ff;
      if (take && q_beat.last) begin
         out_valid_in = 1'b1;
         out_order_in = ord;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         verdict_ff <= tkc_pkg::VERDICT_NONE;
         low_a_ff <= 32'd0;
         low_b_ff <= 32'd0;
         neg_ff <= 1'b0;
         ended_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            if (q_beat.last) begin
               seen_ff <= '0;
               verdict_ff <= tkc_pkg::VERDICT_NONE;
               low_a_ff <= 32'd0;
               low_b_ff <= 32'd0;
               neg_ff <= 1'b0;
               ended_ff <= 1'b0;
            end else begin
               seen_ff <= seen_in;
               verdict_ff <= verdict_in;
               low_a_ff <= low_a_in;
               low_b_ff <= low_b_in;
               if (below_max && q_beat.cls == tkc_pkg::CLS_BYTES) begin
                  neg_ff <= neg_in;
                  ended_ff <= ended_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_order_ff <= out_order_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'd0, out_order_ff};

   property p_seen_bounded;
      @(posedge clock) disable iff (reset) CmpWidth'(seen_ff) <= CmpWidth'(MAX_KEY_WORDS);
   endproperty
   a_seen_bounded: assert property (p_seen_bounded) else $error("word count past limit");

   property p_clear_after_last;
      @(posedge clock) disable iff (reset) (take && q_beat.last) |=>
         (seen_ff == '0 && verdict_ff == tkc_pkg::VERDICT_NONE);
   endproperty
   a_clear_after_last: assert property (p_clear_after_last) else $error("state not cleared");

   property p_order_range;
      @(posedge clock) disable iff (reset) rsp_tvalid |-> out_order_ff <= 3'd4;
   endproperty
   a_order_range: assert property (p_order_range) else $error("order out of range");

endmodule
`default_nettype wire
